[src/lcdwf_pkg.sv]
// Shared types and constants for the LCD window flush sequencer.
// No dependencies; every other file in src imports this package.
package lcdwf_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int RES_BITS       = 12;
  localparam int CFG_IDX_BITS   = 2;
  localparam int BEAT_BITS      = 4;

  localparam logic [RES_BITS-1:0] HRES_RESET = 12'd800;
  localparam logic [RES_BITS-1:0] VRES_RESET = 12'd480;

  localparam logic [CFG_IDX_BITS-1:0] CFG_HRES = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_VRES = 2'd1;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  localparam logic [7:0] CMD_COLUMN = 8'h2A;
  localparam logic [7:0] CMD_ROW    = 8'h2B;
  localparam logic [7:0] CMD_WRITE  = 8'h2C;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_WORD   = 2'd1,
    KIND_REPEAT = 2'd2,
    KIND_NONE   = 2'd3
  } cycle_kind_e;

  // Position within the window command run.
  typedef enum logic [BEAT_BITS-1:0] {
    BEAT_COL_CMD = 4'd0,
    BEAT_LEFT_HI = 4'd1,
    BEAT_LEFT_LO = 4'd2,
    BEAT_RIGHT_HI = 4'd3,
    BEAT_RIGHT_LO = 4'd4,
    BEAT_ROW_CMD = 4'd5,
    BEAT_TOP_HI  = 4'd6,
    BEAT_TOP_LO  = 4'd7,
    BEAT_BOT_HI  = 4'd8,
    BEAT_BOT_LO  = 4'd9,
    BEAT_WR_CMD  = 4'd10
  } beat_e;

  typedef struct packed {
    logic        dnc;
    cycle_kind_e kind;
    logic [15:0] value;
    logic        last;
    logic        done;
  } result_t;

endpackage

[src/lcdwf_cmd_seq.sv]
// Window command run generator: steps through the column/row window bytes
// and the memory-write command. Depends on lcdwf_pkg.
module lcdwf_cmd_seq #(
  parameter int COORD_BITS = lcdwf_pkg::COORD_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  logic                    advance_i,
  input  logic signed [COORD_BITS:0] clip_left_i,
  input  logic signed [COORD_BITS:0] clip_right_i,
  input  logic signed [COORD_BITS:0] clip_top_i,
  input  logic signed [COORD_BITS:0] clip_bottom_i,
  output logic                    pending_o,
  output lcdwf_pkg::result_t      beat_o
);
  import lcdwf_pkg::*;

  beat_e idx_q, idx_d;
  logic  pending_q, pending_d;

  function automatic logic [7:0] hi_byte(logic signed [COORD_BITS:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:8];
  endfunction

  function automatic logic [7:0] lo_byte(logic signed [COORD_BITS:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[7:0];
  endfunction

  // Beat 0 is issued by the top level at the accept edge; start here at 1.
  always_comb begin
    idx_d     = idx_q;
    pending_d = pending_q;
    if (load_i) begin
      idx_d     = BEAT_LEFT_HI;
      pending_d = 1'b1;
    end else if (advance_i && pending_q) begin
      idx_d = beat_e'(BEAT_BITS'(idx_q) + BEAT_BITS'(1));
      if (idx_q == BEAT_WR_CMD) begin
        pending_d = 1'b0;
      end
    end
  end

  always_comb begin
    beat_o = '{dnc: 1'b1, kind: KIND_BYTE, value: '0, last: 1'b0, done: 1'b0};
    unique case (idx_q)
      BEAT_COL_CMD: begin
        beat_o.dnc   = 1'b0;
        beat_o.value = {8'h00, CMD_COLUMN};
      end
      BEAT_LEFT_HI:  beat_o.value = {8'h00, hi_byte(clip_left_i)};
      BEAT_LEFT_LO:  beat_o.value = {8'h00, lo_byte(clip_left_i)};
      BEAT_RIGHT_HI: beat_o.value = {8'h00, hi_byte(clip_right_i)};
      BEAT_RIGHT_LO: beat_o.value = {8'h00, lo_byte(clip_right_i)};
      BEAT_ROW_CMD: begin
        beat_o.dnc   = 1'b0;
        beat_o.value = {8'h00, CMD_ROW};
      end
      BEAT_TOP_HI:   beat_o.value = {8'h00, hi_byte(clip_top_i)};
      BEAT_TOP_LO:   beat_o.value = {8'h00, lo_byte(clip_top_i)};
      BEAT_BOT_HI:   beat_o.value = {8'h00, hi_byte(clip_bottom_i)};
      BEAT_BOT_LO:   beat_o.value = {8'h00, lo_byte(clip_bottom_i)};
      BEAT_WR_CMD: begin
        beat_o.dnc   = 1'b0;
        beat_o.value = {8'h00, CMD_WRITE};
        beat_o.last  = 1'b1;
      end
      default: beat_o.kind = KIND_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= BEAT_COL_CMD;
      pending_q <= 1'b0;
    end else begin
      idx_q     <= idx_d;
      pending_q <= pending_d;
    end
  end

  assign pending_o = pending_q;

endmodule

[src/lcd_window_flush_sequencer_top.sv]
// Top level of the LCD window flush sequencer: clipping, pixel stream state
// and the result register. Depends on lcdwf_pkg and lcdwf_cmd_seq.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o): a start beat carries a signed
//   rectangle; pixel beats then follow for the whole requested area in row
//   order. Output channel (out_valid_o / out_stall_i): one bus cycle per beat.
//   Config channel (cfg_valid_i / cfg_ready_o): screen width (index 0) and
//   height (index 1); always ready, write only while the block is idle.
// A result shows on the output in the cycle after its input beat is taken.
// Throughput: one pixel per cycle while the output is not stalled. A visible start
//   beat yields an 11-beat command run from the result register plus the command
//   sequencer counter, and the input stalls until that run has been issued.
// Reset: screen defaults to 800 x 480, no area is active, output empty.
// Stall: while out_stall_i holds a result, the result register holds and the
//   input stalls; a new beat is taken in the same cycle a result leaves, unless a command run is pending.
module lcd_window_flush_sequencer_top #(
  parameter int COORD_BITS = lcdwf_pkg::COORD_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               req_type_i,
  input  logic signed [15:0]                 area_left_i,
  input  logic signed [15:0]                 area_top_i,
  input  logic signed [15:0]                 area_right_i,
  input  logic signed [15:0]                 area_bottom_i,
  input  logic [15:0]                        pixel_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               data_not_command_o,
  output logic [1:0]                         cycle_kind_o,
  output logic [15:0]                        bus_value_o,
  output logic                               last_o,
  output logic                               flush_done_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lcdwf_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [lcdwf_pkg::RES_BITS-1:0]     cfg_data_i
);
  import lcdwf_pkg::*;

  localparam int CW = COORD_BITS + 1;

  logic [RES_BITS-1:0] hres_q, vres_q;

  logic signed [CW-1:0] clip_left_q, clip_right_q, clip_top_q, clip_bottom_q;
  logic signed [CW-1:0] clip_left_d, clip_right_d, clip_top_d, clip_bottom_d;
  logic signed [CW-1:0] req_left_q, req_right_q, req_bottom_q;
  logic signed [CW-1:0] req_left_d, req_right_d, req_bottom_d;
  logic signed [CW-1:0] cur_col_q, cur_row_q, cur_col_d, cur_row_d;
  logic [15:0]          prev_pixel_q, prev_pixel_d;
  logic row_started_q, row_started_d;
  logic area_visible_q, area_visible_d;
  logic busy_q, busy_d;

  logic signed [CW-1:0] l, t, r, b, cl, ct, cr, cb, hmax, vmax;
  logic empty_area, vis_area, pix_done, pix_vis;

  logic    out_valid_q, out_valid_d;
  result_t res_q, res_d, res_new;
  logic    has_res, free, in_fire, seq_load, seq_pending;
  result_t seq_beat;

  assign cfg_ready_o = 1'b1;

  assign free       = !out_valid_q || !out_stall_i;
  assign in_stall_o = !free || seq_pending;
  assign in_fire    = in_valid_i && !in_stall_o;

  // Take the low COORD_BITS of each corner, sign-extended.
  assign l = CW'(signed'(area_left_i[COORD_BITS-1:0]));
  assign t = CW'(signed'(area_top_i[COORD_BITS-1:0]));
  assign r = CW'(signed'(area_right_i[COORD_BITS-1:0]));
  assign b = CW'(signed'(area_bottom_i[COORD_BITS-1:0]));

  assign hmax = signed'(CW'(hres_q)) - signed'(CW'(1));
  assign vmax = signed'(CW'(vres_q)) - signed'(CW'(1));

  assign cl = (l > signed'(CW'(0))) ? l : '0;
  assign ct = (t > signed'(CW'(0))) ? t : '0;
  assign cr = (r < hmax) ? r : hmax;
  assign cb = (b < vmax) ? b : vmax;

  assign empty_area = (l > r) || (t > b);
  assign vis_area   = (cl <= cr) && (ct <= cb);

  assign pix_done = (cur_col_q == req_right_q) && (cur_row_q == req_bottom_q);
  assign pix_vis  = area_visible_q &&
                    (cur_col_q >= clip_left_q) && (cur_col_q <= clip_right_q) &&
                    (cur_row_q >= clip_top_q) && (cur_row_q <= clip_bottom_q);

  always_comb begin
    clip_left_d    = clip_left_q;
    clip_right_d   = clip_right_q;
    clip_top_d     = clip_top_q;
    clip_bottom_d  = clip_bottom_q;
    req_left_d     = req_left_q;
    req_right_d    = req_right_q;
    req_bottom_d   = req_bottom_q;
    cur_col_d      = cur_col_q;
    cur_row_d      = cur_row_q;
    prev_pixel_d   = prev_pixel_q;
    row_started_d  = row_started_q;
    area_visible_d = area_visible_q;
    busy_d         = busy_q;
    has_res        = 1'b0;
    seq_load       = 1'b0;
    res_new = '{dnc: 1'b0, kind: KIND_NONE, value: '0, last: 1'b1, done: 1'b0};

    if (in_fire) begin
      if (req_type_i == REQ_START) begin
        if (empty_area) begin
          // Nothing to stream: report completion at once.
          busy_d         = 1'b0;
          area_visible_d = 1'b0;
          has_res        = 1'b1;
          res_new.done   = 1'b1;
        end else begin
          clip_left_d    = cl;
          clip_right_d   = cr;
          clip_top_d     = ct;
          clip_bottom_d  = cb;
          req_left_d     = l;
          req_right_d    = r;
          req_bottom_d   = b;
          cur_col_d      = l;
          cur_row_d      = t;
          row_started_d  = 1'b0;
          busy_d         = 1'b1;
          area_visible_d = vis_area;
          if (vis_area) begin
            has_res  = 1'b1;
            seq_load = 1'b1;
            res_new  = '{dnc: 1'b0, kind: KIND_BYTE, value: {8'h00, CMD_COLUMN},
                         last: 1'b0, done: 1'b0};
          end
        end
      end else if (busy_q) begin
        has_res      = 1'b1;
        res_new.done = pix_done;
        if (!pix_vis) begin
          res_new.kind = KIND_NONE;
        end else if (row_started_q && (pixel_i == prev_pixel_q)) begin
          res_new.dnc   = 1'b1;
          res_new.kind  = KIND_REPEAT;
          res_new.value = prev_pixel_q;
        end else begin
          prev_pixel_d  = pixel_i;
          row_started_d = 1'b1;
          res_new.dnc   = 1'b1;
          res_new.kind  = KIND_WORD;
          res_new.value = pixel_i;
        end
        // Advance the raster position over the unclipped area.
        if (pix_done) begin
          busy_d = 1'b0;
        end else if (cur_col_q == req_right_q) begin
          cur_col_d     = req_left_q;
          cur_row_d     = cur_row_q + signed'(CW'(1));
          row_started_d = 1'b0;
        end else begin
          cur_col_d = cur_col_q + signed'(CW'(1));
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (free) begin
      out_valid_d = seq_pending || (in_fire && has_res);
      res_d       = seq_pending ? seq_beat : res_new;
    end
  end

  lcdwf_cmd_seq #(
    .COORD_BITS(COORD_BITS)
  ) u_cmd_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (seq_load),
    .advance_i    (free),
    .clip_left_i  (clip_left_q),
    .clip_right_i (clip_right_q),
    .clip_top_i   (clip_top_q),
    .clip_bottom_i(clip_bottom_q),
    .pending_o    (seq_pending),
    .beat_o       (seq_beat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hres_q <= HRES_RESET;
      vres_q <= VRES_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_HRES: hres_q <= cfg_data_i;
        CFG_VRES: vres_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_left_q    <= '0;
      clip_right_q   <= '0;
      clip_top_q     <= '0;
      clip_bottom_q  <= '0;
      req_left_q     <= '0;
      req_right_q    <= '0;
      req_bottom_q   <= '0;
      cur_col_q      <= '0;
      cur_row_q      <= '0;
      prev_pixel_q   <= '0;
      row_started_q  <= 1'b0;
      area_visible_q <= 1'b0;
      busy_q         <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      clip_left_q    <= clip_left_d;
      clip_right_q   <= clip_right_d;
      clip_top_q     <= clip_top_d;
      clip_bottom_q  <= clip_bottom_d;
      req_left_q     <= req_left_d;
      req_right_q    <= req_right_d;
      req_bottom_q   <= req_bottom_d;
      cur_col_q      <= cur_col_d;
      cur_row_q      <= cur_row_d;
      prev_pixel_q   <= prev_pixel_d;
      row_started_q  <= row_started_d;
      area_visible_q <= area_visible_d;
      busy_q         <= busy_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o        = out_valid_q;
  assign data_not_command_o = res_q.dnc;
  assign cycle_kind_o       = res_q.kind;
  assign bus_value_o        = res_q.value;
  assign last_o             = res_q.last;
  assign flush_done_o       = res_q.done;

endmodule

[src/lcdwf_checker.sv]
// Port-level checks for the LCD window flush sequencer, bound to the top
// level. Depends on lcdwf_pkg and lcd_window_flush_sequencer_top.
module lcdwf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        data_not_command_o,
  input logic [1:0]  cycle_kind_o,
  input logic [15:0] bus_value_o,
  input logic        last_o,
  input logic        flush_done_o
);
  import lcdwf_pkg::*;

  // Hold the result beat while the receiver stalls.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(bus_value_o) &&
      $stable(cycle_kind_o) && $stable(last_o) && $stable(flush_done_o))
    else $error("result changed while stalled");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && flush_done_o |-> last_o)
    else $error("flush_done without last");

  a_none_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (cycle_kind_o == KIND_NONE) |->
      !data_not_command_o && (bus_value_o == 16'h0000))
    else $error("no-cycle beat carries bus data");

  a_word_is_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((cycle_kind_o == KIND_WORD) || (cycle_kind_o == KIND_REPEAT))
      |-> data_not_command_o && last_o)
    else $error("pixel write marked as command or not last");

  a_byte_narrow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (cycle_kind_o == KIND_BYTE) |->
      (bus_value_o[15:8] == 8'h00) && !flush_done_o)
    else $error("byte write wider than a byte");

endmodule

bind lcd_window_flush_sequencer_top lcdwf_checker u_lcdwf_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .data_not_command_o(data_not_command_o),
  .cycle_kind_o      (cycle_kind_o),
  .bus_value_o       (bus_value_o),
  .last_o            (last_o),
  .flush_done_o      (flush_done_o)
);

[tb/lcd_window_flush_sequencer_top_test.sv]
// Self-checking testbench for lcd_window_flush_sequencer_top: directed and random
// window flushes with an in-bench bus cycle predictor and random idling on both sides.
// Depends on lcdwf_pkg and the RTL under src.
`timescale 1ns / 1ps

module lcd_window_flush_sequencer_top_test;
  import lcdwf_pkg::*;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic                    req_type_i = REQ_START;
  logic signed [15:0]      area_left_i = '0;
  logic signed [15:0]      area_top_i = '0;
  logic signed [15:0]      area_right_i = '0;
  logic signed [15:0]      area_bottom_i = '0;
  logic [15:0]             pixel_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic                    data_not_command_o;
  logic [1:0]              cycle_kind_o;
  logic [15:0]             bus_value_o;
  logic                    last_o;
  logic                    flush_done_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = CFG_HRES;
  logic [RES_BITS-1:0]     cfg_data_i = '0;

  // Predictor state: screen size, clipped window, requested span and scan position.
  int          scr_w = int'(HRES_RESET);
  int          scr_h = int'(VRES_RESET);
  int          win_l = 0, win_r = 0, win_t = 0, win_b = 0;
  int          span_l = 0, span_r = 0, span_b = 0;
  int          col = 0, row = 0;
  logic [15:0] last_px = '0;
  bit          row_open = 1'b0;
  bit          on_screen = 1'b0;
  bit          streaming = 1'b0;

  result_t     bus_cycles_due[$];
  int          errors = 0;
  bit          calm = 1'b0;
  logic [15:0] px_hist = '0;
  int          stall_left = 0;
  int          run_left = 0;

  lcd_window_flush_sequencer_top u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .req_type_i         (req_type_i),
    .area_left_i        (area_left_i),
    .area_top_i         (area_top_i),
    .area_right_i       (area_right_i),
    .area_bottom_i      (area_bottom_i),
    .pixel_i            (pixel_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .data_not_command_o (data_not_command_o),
    .cycle_kind_o       (cycle_kind_o),
    .bus_value_o        (bus_value_o),
    .last_o             (last_o),
    .flush_done_o       (flush_done_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  task automatic push_due(input logic dnc, input cycle_kind_e kind, input logic [15:0] value,
                          input logic last, input logic done);
    result_t r;
    r.dnc   = dnc;
    r.kind  = kind;
    r.value = value;
    r.last  = last;
    r.done  = done;
    bus_cycles_due.push_back(r);
  endtask

  task automatic push_window(input logic [7:0] cmd, input int lo, input int hi);
    logic [15:0] a, b;
    a = lo[15:0];
    b = hi[15:0];
    push_due(1'b0, KIND_BYTE, {8'h00, cmd}, 1'b0, 1'b0);
    push_due(1'b1, KIND_BYTE, {8'h00, a[15:8]}, 1'b0, 1'b0);
    push_due(1'b1, KIND_BYTE, {8'h00, a[7:0]}, 1'b0, 1'b0);
    push_due(1'b1, KIND_BYTE, {8'h00, b[15:8]}, 1'b0, 1'b0);
    push_due(1'b1, KIND_BYTE, {8'h00, b[7:0]}, 1'b0, 1'b0);
  endtask

  task automatic predict_bus_cycles(input logic typ, input logic signed [15:0] l, t, r, b,
                                    input logic [15:0] px);
    int  il, it, ir, ib;
    bit  fin, vis;
    il = int'(l);
    it = int'(t);
    ir = int'(r);
    ib = int'(b);
    if (typ == REQ_START) begin
      if (il > ir || it > ib) begin
        streaming = 1'b0;
        on_screen = 1'b0;
        push_due(1'b0, KIND_NONE, 16'h0000, 1'b1, 1'b1);
        return;
      end
      win_l = (il > 0) ? il : 0;
      win_t = (it > 0) ? it : 0;
      win_r = (ir < scr_w - 1) ? ir : scr_w - 1;
      win_b = (ib < scr_h - 1) ? ib : scr_h - 1;
      span_l = il;
      span_r = ir;
      span_b = ib;
      col = il;
      row = it;
      row_open = 1'b0;
      streaming = 1'b1;
      on_screen = (win_l <= win_r) && (win_t <= win_b);
      if (!on_screen) return;
      push_window(CMD_COLUMN, win_l, win_r);
      push_window(CMD_ROW, win_t, win_b);
      push_due(1'b0, KIND_BYTE, {8'h00, CMD_WRITE}, 1'b1, 1'b0);
    end else begin
      if (!streaming) return;
      fin = (col == span_r) && (row == span_b);
      vis = on_screen && col >= win_l && col <= win_r && row >= win_t && row <= win_b;
      if (!vis) begin
        push_due(1'b0, KIND_NONE, 16'h0000, 1'b1, fin);
      end else if (row_open && px == last_px) begin
        push_due(1'b1, KIND_REPEAT, last_px, 1'b1, fin);
      end else begin
        last_px = px;
        row_open = 1'b1;
        push_due(1'b1, KIND_WORD, px, 1'b1, fin);
      end
      if (fin) begin
        streaming = 1'b0;
      end else if (col == span_r) begin
        col = span_l;
        row++;
        row_open = 1'b0;
      end else begin
        col++;
      end
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic compare_field(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (bus_cycles_due.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual dnc %b kind %0d value %h",
                 $time, data_not_command_o, cycle_kind_o, bus_value_o);
        errors++;
      end else begin
        want = bus_cycles_due.pop_front();
        compare_field("data_not_command", 16'(data_not_command_o), 16'(want.dnc));
        compare_field("cycle_kind", 16'(cycle_kind_o), 16'(want.kind));
        compare_field("bus_value", bus_value_o, want.value);
        compare_field("last", 16'(last_o), 16'(want.last));
        compare_field("flush_done", 16'(flush_done_o), 16'(want.done));
      end
    end
  end

  // Output back-pressure: random stall bursts between runs of open cycles.
  always @(posedge clk_i) begin
    if (stall_left == 0 && run_left == 0) begin
      if (!calm && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 14);
      else run_left = $urandom_range(1, 40);
    end
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
      // Follow every stall burst with open cycles.
      if (stall_left == 0) run_left = $urandom_range(1, 40);
    end else begin
      out_stall_i <= 1'b0;
      run_left--;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic push_beat(input logic typ, input logic signed [15:0] l, t, r, b,
                           input logic [15:0] px);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= typ;
    area_left_i   <= l;
    area_top_i    <= t;
    area_right_i  <= r;
    area_bottom_i <= b;
    pixel_i       <= px;
    do @(posedge clk_i); while (in_stall_o);
    predict_bus_cycles(typ, l, t, r, b, px);
  endtask

  task automatic send_area(input int l, input int t, input int r, input int b);
    push_beat(REQ_START, 16'(l), 16'(t), 16'(r), 16'(b), 16'($urandom));
  endtask

  task automatic send_pixel(input logic [15:0] px);
    push_beat(REQ_PIXEL, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), px);
  endtask

  // Favor repeats so runs of equal pixels show up within rows.
  function automatic logic [15:0] next_pixel();
    case ($urandom_range(0, 5))
      0, 1, 2: ;
      3: px_hist = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: px_hist = 16'($urandom_range(0, 16'hFFFF));
    endcase
    return px_hist;
  endfunction

  task automatic stream_pixels(input int n);
    repeat (n) send_pixel(next_pixel());
  endtask

  // Drop valid, drain all expected beats, then allow for starts with no output.
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (bus_cycles_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data[RES_BITS-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_HRES) scr_w = int'(data[RES_BITS-1:0]);
    else scr_h = int'(data[RES_BITS-1:0]);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_screen(input int w, input int h);
    wait_quiet();
    write_reg(CFG_HRES, w);
    write_reg(CFG_VRES, h);
  endtask

  function automatic int pick_origin(input int span, input int extent);
    case ($urandom_range(0, 9))
      0, 1, 2: return int'($urandom_range(0, span + 1)) - span;
      3, 4, 5: return extent - span + int'($urandom_range(0, span + 1));
      6, 7:    return int'($urandom_range(0, extent));
      8:       return int'($urandom_range(4200, 32700));
      default: return -int'($urandom_range(100, 32768));
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_default_screen();
    // Corner straddle: same pixel everywhere, so each row opens with a word.
    send_area(-2, -1, 1, 1);
    repeat (12) send_pixel(16'hFFFF);
    send_area(10, 20, 12, 20);
    send_pixel(16'h1234);
    send_pixel(16'h1234);
    send_pixel(16'h0000);
  endtask

  task automatic test_clipped_edges();
    send_area(798, 479, 800, 480);
    stream_pixels(6);
  endtask

  task automatic test_degenerate_areas();
    send_area(32767, 0, -32768, 0);
    send_area(0, 5, 3, 4);
    send_area(-32768, -32768, -32767, -32768);
    stream_pixels(2);
    send_area(32767, 32767, 32767, 32767);
    stream_pixels(1);
    // Idle pixels are ignored.
    stream_pixels(2);
    // Abandon an area midway.
    send_area(0, 0, 3, 1);
    stream_pixels(3);
    send_area(5, 5, 6, 5);
    stream_pixels(2);
  endtask

  task automatic test_screen_extremes();
    write_screen(1, 4095);
    send_area(-1, 4094, 1, 4095);
    stream_pixels(6);
    write_screen(4095, 1);
    send_area(4094, -1, 4095, 1);
    stream_pixels(6);
    write_screen(0, 480);
    send_area(0, 0, 1, 0);
    stream_pixels(2);
    write_screen(800, 0);
    send_area(0, 0, 1, 0);
    stream_pixels(2);
  endtask

  task automatic test_random_flushes();
    int sent, sel, w, h, l, t, n;
    sent = 0;
    while (sent < 300) begin
      if (!streaming && $urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 2))
          0: write_screen($urandom_range(1, 12), $urandom_range(1, 12));
          1: write_screen($urandom_range(1, 4095), $urandom_range(1, 4095));
          default: write_screen($urandom_range(0, 1) ? 1 : 4095, $urandom_range(0, 1) ? 1 : 4095);
        endcase
      end
      sel = $urandom_range(0, 19);
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 4);
      l = pick_origin(w, scr_w);
      t = pick_origin(h, scr_h);
      if (sel == 0) begin
        if ($urandom_range(0, 1)) send_area(l, t, l - int'($urandom_range(1, 5)), t + h - 1);
        else send_area(l, t, l + w - 1, t - int'($urandom_range(1, 5)));
        sent++;
      end else if (sel == 1) begin
        n = $urandom_range(1, 3);
        stream_pixels(n);
        sent += n;
      end else begin
        send_area(l, t, l + w - 1, t + h - 1);
        n = (sel < 4) ? $urandom_range(0, w * h - 1) : w * h;
        stream_pixels(n);
        sent += n + 1;
      end
    end
  endtask

  task automatic test_steady_stream();
    write_screen(16, 8);
    calm = 1'b1;
    repeat (6) begin
      send_area(pick_origin(4, 16), pick_origin(2, 8), 0, 0);
      // Each start ends at column 0 and row 0, so an origin past either gives an empty area.
    end
    repeat (6) begin
      send_area(13, 6, 17, 8);
      stream_pixels(15);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_default_screen();
    test_clipped_edges();
    test_degenerate_areas();
    test_screen_extremes();
    test_random_flushes();
    test_steady_stream();
    wait_quiet();
    repeat (16) @(posedge clk_i);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
